@@ rtl/msu_pkg.sv @@
package msu_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_PASS  = 7'b0000010,
        ST_PAIR  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_MERGE = 7'b0010000,
        ST_FETCH = 7'b0100000,
        ST_SHOW  = 7'b1000000
    } seq_state_t;

    typedef struct packed {
        logic   we0;
        logic   we1;
        value_t wdata;
    } bank_wr_t;

endpackage

@@ rtl/msu_if.sv @@
interface msu_in_if;
    logic            valid;
    logic            ready;
    msu_pkg::value_t value;
    logic            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface msu_out_if;
    logic            valid;
    logic            ready;
    msu_pkg::value_t value_res;
    logic            last_res;
    logic            overflowed;

    modport source (output valid, output value_res, output last_res, output overflowed,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflowed,
                    output ready);
endinterface

@@ rtl/msu_bank.sv @@
module msu_bank #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  msu_pkg::value_t wdata,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output msu_pkg::value_t rdata_a,
    output msu_pkg::value_t rdata_b
);
    import msu_pkg::*;

    value_t mem [DEPTH];
    value_t rdata_a_reg;
    value_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/msu_seq.sv @@
module msu_seq #(
    parameter int MAX_ITEMS = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    msu_in_if.sink             items,
    msu_out_if.source          results,
    output msu_pkg::bank_wr_t  wr,
    output logic [AW-1:0]      waddr,
    output logic [AW-1:0]      raddr_a,
    output logic [AW-1:0]      raddr_b,
    input  msu_pkg::value_t    rd0_a,
    input  msu_pkg::value_t    rd0_b,
    input  msu_pkg::value_t    rd1_a,
    input  msu_pkg::value_t    rd1_b
);
    import msu_pkg::*;

    localparam int SW = CW + 2;

    seq_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic          src_sel_reg, src_sel_next;
    logic [SW-1:0] width_reg, width_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [SW-1:0] i_reg, i_next;
    logic [SW-1:0] j_reg, j_next;
    logic [SW-1:0] i_end_reg, i_end_next;
    logic [SW-1:0] j_end_reg, j_end_next;
    logic [CW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    value_t        value_res_reg;
    logic          last_res_reg;
    logic          overflowed_reg;

    value_t        src_a;
    value_t        src_b;
    logic          left_ok;
    logic          right_ok;
    logic          take_left;
    logic [SW-1:0] n_ext;
    logic [SW-1:0] run_mid;
    logic [SW-1:0] run_hi;
    logic [CW-1:0] k_inc;
    logic          load_show;

    assign src_a     = src_sel_reg ? rd1_a : rd0_a;
    assign src_b     = src_sel_reg ? rd1_b : rd0_b;
    assign left_ok   = i_reg < i_end_reg;
    assign right_ok  = j_reg < j_end_reg;
    assign take_left = left_ok && (!right_ok || (src_a <= src_b));
    assign n_ext     = SW'(count_reg);
    assign run_mid   = ((lo_reg + width_reg) < n_ext) ? lo_reg + width_reg : n_ext;
    assign run_hi    = ((lo_reg + (width_reg << 1)) < n_ext) ?
                       lo_reg + (width_reg << 1) : n_ext;
    assign k_inc     = k_reg + CW'(1);
    assign load_show = (state_reg == ST_SHOW);

    assign raddr_a = (state_reg == ST_FETCH) ? k_reg[AW-1:0] : i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];

    assign items.ready        = (state_reg == ST_LOAD);
    assign results.valid      = out_valid_reg;
    assign results.value_res  = value_res_reg;
    assign results.last_res   = last_res_reg;
    assign results.overflowed = overflowed_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        src_sel_next   = src_sel_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        i_end_next     = i_end_reg;
        j_end_next     = j_end_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !results.ready;
        wr.we0         = 1'b0;
        wr.we1         = 1'b0;
        wr.wdata       = items.value;
        waddr          = count_reg[AW-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (items.valid)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        wr.we0     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (items.last)
                    begin
                        width_next   = SW'(1);
                        src_sel_next = 1'b0;
                        state_next   = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                if (width_reg >= n_ext)
                begin
                    k_next     = '0;
                    state_next = ST_FETCH;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                if (lo_reg >= n_ext)
                begin
                    width_next   = width_reg << 1;
                    src_sel_next = !src_sel_reg;
                    state_next   = ST_PASS;
                end
                else
                begin
                    i_next     = lo_reg;
                    i_end_next = run_mid;
                    j_next     = run_mid;
                    j_end_next = run_hi;
                    k_next     = lo_reg[CW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr.we0   = src_sel_reg;
                wr.we1   = !src_sel_reg;
                wr.wdata = take_left ? src_a : src_b;
                waddr    = k_reg[AW-1:0];
                k_next   = k_inc;
                if (take_left)
                begin
                    i_next = i_reg + SW'(1);
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
                if ((take_left && (i_reg + SW'(1) == i_end_reg) && !right_ok) ||
                    (!take_left && !left_ok && (j_reg + SW'(1) == j_end_reg)))
                begin
                    lo_next    = j_end_reg;
                    state_next = ST_PAIR;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_FETCH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_SHOW;
                end
            end
            ST_SHOW:
            begin
                out_valid_next = 1'b1;
                k_next         = k_inc;
                if (k_inc == count_reg)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            src_sel_reg   <= 1'b0;
            width_reg     <= '0;
            lo_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            i_end_reg     <= '0;
            j_end_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            src_sel_reg   <= src_sel_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            i_end_reg     <= i_end_next;
            j_end_reg     <= j_end_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result payload until the next one is shown
    always_ff @(posedge clk)
    begin
        if (load_show)
        begin
            value_res_reg  <= src_a;
            last_res_reg   <= (k_inc == count_reg);
            overflowed_reg <= drop_reg;
        end
    end

endmodule

@@ rtl/merge_sorter_unit.sv @@
// channel   dir  handshake      payload
// items     in   valid/ready    value[31:0] signed, last
// results   out  valid/ready    value_res[31:0] signed, last_res, overflowed
//
// Loading accepts one request per cycle. After the last request a set of n
// elements runs ceil(log2 n) merge passes through one comparator and the
// two banks (one write and two read ports each), each element read and then
// merged; the results are then fetched and shown one at a time.
// Reset clears the sequencer and counters; bank contents are left as they are.
// Input is not ready while sorting or emitting; a stalled result holds.
module merge_sorter_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    msu_in_if.sink    items,
    msu_out_if.source results
);
    import msu_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    bank_wr_t      wr;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    value_t        rd0_a;
    value_t        rd0_b;
    value_t        rd1_a;
    value_t        rd1_b;

    msu_seq #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .wr      (wr),
        .waddr   (waddr),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rd0_a   (rd0_a),
        .rd0_b   (rd0_b),
        .rd1_a   (rd1_a),
        .rd1_b   (rd1_b)
    );

    msu_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (wr.we0),
        .waddr   (waddr),
        .wdata   (wr.wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    msu_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_scratch (
        .clk     (clk),
        .we      (wr.we1),
        .waddr   (waddr),
        .wdata   (wr.wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

typedef struct packed {
    msu_pkg::value_t value_res;
    logic            last_res;
    logic            overflowed;
} sorted_item_t;

class sort_scoreboard;
    int              capacity;
    msu_pkg::value_t loading[$];
    bit              dropped;
    sorted_item_t    sorted_q[$];
    int              errors;
    int              results_seen;
    int              sets_seen;
    int              overflow_sets;
    int              largest_set;

    function new(int cap);
        capacity      = cap;
        dropped       = 1'b0;
        errors        = 0;
        results_seen  = 0;
        sets_seen     = 0;
        overflow_sets = 0;
        largest_set   = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    // stable ascending insertion sort: equal keys keep arrival order
    function void note_request(msu_pkg::value_t v, logic l);
        msu_pkg::value_t arr[];
        msu_pkg::value_t key;
        sorted_item_t    item;
        int              j;
        if (loading.size() < capacity)
            loading.push_back(v);
        else
            dropped = 1'b1;
        if (l)
        begin
            arr = new[loading.size()];
            foreach (loading[i])
                arr[i] = loading[i];
            for (int i = 1; i < arr.size(); i++)
            begin
                key = arr[i];
                j = i - 1;
                while (j >= 0 && arr[j] > key)
                begin
                    arr[j + 1] = arr[j];
                    j--;
                end
                arr[j + 1] = key;
            end
            for (int i = 0; i < arr.size(); i++)
            begin
                item.value_res  = arr[i];
                item.last_res   = (i == arr.size() - 1);
                item.overflowed = dropped;
                sorted_q.push_back(item);
            end
            sets_seen++;
            if (dropped)
                overflow_sets++;
            if (arr.size() > largest_set)
                largest_set = arr.size();
            loading.delete();
            dropped = 1'b0;
        end
    endfunction

    task check_result(msu_pkg::value_t v, logic l, logic o);
        sorted_item_t exp_item;
        results_seen++;
        if (sorted_q.size() == 0)
        begin
            report($sformatf("unexpected result value_res=%0d", v));
        end
        else
        begin
            exp_item = sorted_q.pop_front();
            if (v !== exp_item.value_res)
                report($sformatf("value_res %0d, want %0d", v, exp_item.value_res));
            if (l !== exp_item.last_res)
                report($sformatf("last_res %b, want %b", l, exp_item.last_res));
            if (o !== exp_item.overflowed)
                report($sformatf("overflowed %b, want %b", o, exp_item.overflowed));
        end
    endtask
endclass

module tb_top;
    import msu_pkg::*;

    localparam int CAP         = 64;
    localparam int RAND_ITEMS  = 440;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   items_stored;
    int   quiet_cycles = 0;

    value_t set_buf[$];

    sort_scoreboard sb;

    msu_in_if  items_ch ();
    msu_out_if results_ch ();

    merge_sorter_unit #(
        .MAX_ITEMS(CAP)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    always #10 clk = ~clk;

    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(7))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2:       v = $signed($urandom_range(8)) - 4;
            3:       v = $signed($urandom_range(8)) - 4;
            4:       v = $signed($urandom_range(2000)) - 1000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_set();
        for (int i = 0; i < set_buf.size(); i++)
        begin
            while ($urandom_range(99) < send_idle)
            begin
                items_ch.valid <= 1'b0;
                @(posedge clk);
            end
            items_ch.valid <= 1'b1;
            items_ch.value <= set_buf[i];
            items_ch.last  <= (i == set_buf.size() - 1);
            do
                @(posedge clk);
            while (!items_ch.ready);
            sb.note_request(set_buf[i], i == set_buf.size() - 1);
        end
        items_stored += (set_buf.size() < CAP) ? set_buf.size() : CAP;
    endtask

    // drop the request line, then wait for every expected result
    task automatic wait_drained();
        items_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.sorted_q.size() != 0);
    endtask

    // check, then draw the next ready
    always @(posedge clk)
    begin
        if (results_ch.valid && results_ch.ready)
            sb.check_result(results_ch.value_res, results_ch.last_res, results_ch.overflowed);
        results_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int n;
        int r;
        sb               = new(CAP);
        rst_n            = 1'b0;
        send_idle        = 30;
        recv_idle        = 61;
        items_stored     = 0;
        items_ch.valid   <= 1'b0;
        items_ch.value   <= '0;
        items_ch.last    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_buf = '{32'sh7fffffff};
        send_set();
        set_buf = '{32'sh80000000};
        send_set();
        set_buf = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1};
        send_set();
        set_buf = '{3, -3, 3, 3, -3, 0};
        send_set();
        set_buf = '{7, 2};
        send_set();
        set_buf = '{-2, 9};
        send_set();
        set_buf = '{4, 3, 2, 1, 0, -1, -2};
        send_set();
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 30;
                    recv_idle = 61;
                end
                1:
                begin
                    send_idle = 61;
                    recv_idle = 30;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            while (items_stored < (phase + 1) * RAND_ITEMS / 3)
            begin
                r = $urandom_range(99);
                if (r < 78)
                    n = $urandom_range(8, 1);
                else if (r < 90)
                    n = $urandom_range(CAP - 1, 9);
                else
                    n = $urandom_range(CAP + 4, CAP - 1);
                set_buf.delete();
                repeat (n) set_buf.push_back(pick_value());
                send_set();
                // now and then hold off the sender until the sorter has emptied
                if ($urandom_range(19) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.sorted_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.sorted_q.size()));

        $display("Sorted %0d sets (%0d with dropped requests, largest %0d elements),",
                 sb.sets_seen, sb.overflow_sets, sb.largest_set);
        $display("checked %0d results under three idling patterns; %0d mismatches.",
                 sb.results_seen, sb.errors);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/msu_pkg.sv
rtl/msu_if.sv
rtl/msu_bank.sv
rtl/msu_seq.sv
rtl/merge_sorter_unit.sv
tb/sv/tb_top.sv
